FILE: design/dccs_pkg.sv
// shared constants, codes and types of the dac code calibration search
package dccs_pkg;

    // fixed point format of all voltages
    localparam int FRAC_BITS = 16;

    // field widths
    localparam int CH_W     = 2;
    localparam int CODE_W   = 16;
    localparam int TGT_W    = 20;
    localparam int TOL_W    = 20;
    localparam int RD_IN_W  = 21;
    localparam int ST_W     = 2;
    localparam int CFG_W    = 16;
    localparam int IDX_W    = 2;

    localparam logic [CODE_W-1:0] CODE_MAX = {CODE_W{1'b1}};
    localparam logic [TOL_W-1:0]  TOL_MAX  = {TOL_W{1'b1}};

    // register reset values
    localparam logic [CFG_W-1:0] INIT_TOL_RST  = CFG_W'(66);
    localparam logic [CFG_W-1:0] ZERO_CODE_RST = CFG_W'(3000);
    localparam logic [CFG_W-1:0] FULL_CODE_RST = CFG_W'(64000);

    // register indexes
    localparam logic [IDX_W-1:0] REG_INIT_TOL  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_ZERO_CODE = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_FULL_CODE = IDX_W'(2);

    // commands
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_READING = 1'b1;

    // result status
    localparam logic [ST_W-1:0] ST_MEASURE = ST_W'(0);
    localparam logic [ST_W-1:0] ST_DONE    = ST_W'(1);
    localparam logic [ST_W-1:0] ST_IGNORED = ST_W'(2);

    // reading width after inversion, wide enough for 10 V plus a negative reading
    localparam int RD_W = (FRAC_BITS + 6 > 22) ? FRAC_BITS + 6 : 22;
    localparam logic [RD_W-1:0] TEN_VOLTS = RD_W'(longint'(10) << FRAC_BITS);

    // first guess: floor(floor(t * 65535 / 2^frac) / 10), divide by 10 via reciprocal
    localparam int SCALED_W = TGT_W + CODE_W;
    localparam int QW       = SCALED_W - FRAC_BITS;
    localparam int RECIP_SH = QW + 4;
    localparam int RECIP_W  = RECIP_SH - 3;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((longint'(1) << RECIP_SH) + 9) / 10);
    localparam int PROD_W   = QW + RECIP_W;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [CFG_W-1:0] init_tol;
        logic [CFG_W-1:0] zero_code;
        logic [CFG_W-1:0] full_code;
    } t_cfg;

    // classified item handed from front to back
    typedef struct packed {
        logic              is_start;
        logic [CH_W-1:0]   channel;
        logic [TGT_W-1:0]  target;
        logic              invert;
        logic [CODE_W-1:0] guess;
        logic [RD_W-1:0]   rd_plain;
        logic [RD_W-1:0]   rd_inv;
    } t_item;

endpackage

FILE: design/dccs_if.sv
// stream and configuration channel interfaces
interface dccs_in_if import dccs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                command;
    logic [CH_W-1:0]     channel;
    logic [TGT_W-1:0]    target_voltage;
    logic                invert_reading;
    logic [RD_IN_W-1:0]  reading;

    modport source (output valid, command, channel, target_voltage, invert_reading, reading,
                    input ready);
    modport sink   (input valid, command, channel, target_voltage, invert_reading, reading,
                    output ready);
endinterface

interface dccs_out_if import dccs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   out_channel;
    logic [CODE_W-1:0] dac_code;
    logic [ST_W-1:0]   status;
    logic [TOL_W-1:0]  current_tolerance;

    modport source (output valid, out_channel, dac_code, status, current_tolerance,
                    input ready);
    modport sink   (input valid, out_channel, dac_code, status, current_tolerance,
                    output ready);
endinterface

interface dccs_cfg_if import dccs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/dccs_front.sv
// front end: accepts beats, computes the first guess and reading variants
module dccs_front import dccs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dccs_in_if.sink    i_in,
    input  t_cfg       i_cfg,
    input  logic       i_full,
    output logic       o_push,
    output t_item      o_item
);

    logic                adv;
    logic                acc;
    logic [SCALED_W-1:0] scaled;
    logic [QW-1:0]       n_q;
    logic [RD_W-1:0]     rd_ext;
    logic [PROD_W-1:0]   g;

    logic                r_v1;
    logic                r_s1_start;
    logic [CH_W-1:0]     r_s1_ch;
    logic [TGT_W-1:0]    r_s1_tgt;
    logic                r_s1_inv;
    logic [QW-1:0]       r_s1_q;
    logic [RD_W-1:0]     r_s1_plain;
    logic [RD_W-1:0]     r_s1_rinv;

    logic                r_v2;
    logic                r_s2_start;
    logic [CH_W-1:0]     r_s2_ch;
    logic [TGT_W-1:0]    r_s2_tgt;
    logic                r_s2_inv;
    logic [PROD_W-1:0]   r_s2_prod;
    logic [RD_W-1:0]     r_s2_plain;
    logic [RD_W-1:0]     r_s2_rinv;

    // whole pipe moves unless its last stage is blocked by a full queue
    assign adv        = !(r_v2 && i_full);
    assign i_in.ready = adv;
    assign acc        = i_in.valid && adv;

    // t * 65535 as shift and subtract
    assign scaled = {i_in.target_voltage, CODE_W'(0)} - SCALED_W'(i_in.target_voltage);
    assign n_q    = QW'(scaled >> FRAC_BITS);
    assign rd_ext = RD_W'($signed(i_in.reading));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v1 <= acc;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_start <= (i_in.command == CMD_START);
            r_s1_ch    <= i_in.channel;
            r_s1_tgt   <= i_in.target_voltage;
            r_s1_inv   <= i_in.invert_reading;
            r_s1_q     <= n_q;
            r_s1_plain <= rd_ext;
            r_s1_rinv  <= TEN_VOLTS - rd_ext;

            r_s2_start <= r_s1_start;
            r_s2_ch    <= r_s1_ch;
            r_s2_tgt   <= r_s1_tgt;
            r_s2_inv   <= r_s1_inv;
            r_s2_prod  <= PROD_W'(r_s1_q) * PROD_W'(RECIP);
            r_s2_plain <= r_s1_plain;
            r_s2_rinv  <= r_s1_rinv;
        end
    end

    // quotient by 10, then the end-code substitutes
    assign g = r_s2_prod >> RECIP_SH;

    always_comb begin
        o_item.is_start = r_s2_start;
        o_item.channel  = r_s2_ch;
        o_item.target   = r_s2_tgt;
        o_item.invert   = r_s2_inv;
        o_item.rd_plain = r_s2_plain;
        o_item.rd_inv   = r_s2_rinv;
        priority if (g == '0) begin
            o_item.guess = i_cfg.zero_code;
        end else if (g >= PROD_W'(CODE_MAX)) begin
            o_item.guess = i_cfg.full_code;
        end else begin
            o_item.guess = g[CODE_W-1:0];
        end
    end

    assign o_push = r_v2 && !i_full;

endmodule

FILE: design/dccs_fifo.sv
// short queue of classified items between front and back
module dccs_fifo import dccs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("pop from empty queue");
`endif

endmodule

FILE: design/dccs_back.sv
// back end: search state, one step per item, registered result
module dccs_back import dccs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_init_tol,
    input  logic             i_empty,
    input  t_item            i_item,
    output logic             o_pop,
    dccs_out_if.source       o_out
);

    logic              r_searching;
    logic [CODE_W-1:0] r_guess;
    logic [CODE_W-1:0] r_prev;
    logic [TOL_W-1:0]  r_tol;
    logic [TGT_W-1:0]  r_target;
    logic              r_invert;
    logic [CH_W-1:0]   r_channel;
    logic              r_out_vld;
    logic [ST_W-1:0]   r_out_status;

    logic              n_searching;
    logic [CODE_W-1:0] n_guess;
    logic [CODE_W-1:0] n_prev;
    logic [TOL_W-1:0]  n_tol;
    logic [TGT_W-1:0]  n_target;
    logic              n_invert;
    logic [CH_W-1:0]   n_channel;
    logic [ST_W-1:0]   n_status;

    logic signed [RD_W-1:0] rd;
    logic signed [RD_W-1:0] tg;
    logic signed [RD_W:0]   d;
    logic [RD_W:0]          absd;
    logic                   gt;
    logic                   lt;
    logic [TOL_W:0]         grown;
    logic [TOL_W-1:0]       tol_grown;
    logic                   reversal;
    logic [TOL_W-1:0]       step_tol;

    assign o_pop = !i_empty && (!r_out_vld || o_out.ready);

    assign rd   = $signed(r_invert ? i_item.rd_inv : i_item.rd_plain);
    assign tg   = $signed({{(RD_W - TGT_W){1'b0}}, r_target});
    assign gt   = rd > tg;
    assign lt   = rd < tg;
    assign d    = {rd[RD_W-1], rd} - {tg[RD_W-1], tg};
    assign absd = gt ? d : -d;

    assign grown     = (TOL_W+1)'(r_tol) + (TOL_W+1)'(r_tol >> 2);
    assign tol_grown = grown[TOL_W] ? TOL_MAX : grown[TOL_W-1:0];
    assign reversal  = (gt && (r_prev < r_guess)) || (lt && (r_prev > r_guess));
    assign step_tol  = reversal ? tol_grown : r_tol;

    always_comb begin
        n_searching = r_searching;
        n_guess     = r_guess;
        n_prev      = r_prev;
        n_tol       = r_tol;
        n_target    = r_target;
        n_invert    = r_invert;
        n_channel   = r_channel;
        n_status    = ST_MEASURE;
        priority if (i_item.is_start) begin
            n_channel   = i_item.channel;
            n_target    = i_item.target;
            n_invert    = i_item.invert;
            n_guess     = i_item.guess;
            n_prev      = i_item.guess;
            n_tol       = TOL_W'(i_init_tol);
            n_searching = 1'b1;
        end else if (!r_searching) begin
            n_status = ST_IGNORED;
        end else begin
            n_tol = step_tol;
            if (gt) begin
                n_prev  = r_guess;
                n_guess = (r_guess != '0) ? r_guess - CODE_W'(1) : r_guess;
            end else if (lt) begin
                n_prev  = r_guess;
                n_guess = (r_guess != CODE_MAX) ? r_guess + CODE_W'(1) : r_guess;
            end
            if (absd <= (RD_W+1)'(step_tol)) begin
                n_searching = 1'b0;
                n_status    = ST_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_searching  <= 1'b0;
            r_guess      <= '0;
            r_prev       <= '0;
            r_tol        <= TOL_W'(INIT_TOL_RST);
            r_target     <= '0;
            r_invert     <= 1'b0;
            r_channel    <= '0;
            r_out_vld    <= 1'b0;
            r_out_status <= ST_MEASURE;
        end else begin
            if (o_pop) begin
                r_searching  <= n_searching;
                r_guess      <= n_guess;
                r_prev       <= n_prev;
                r_tol        <= n_tol;
                r_target     <= n_target;
                r_invert     <= n_invert;
                r_channel    <= n_channel;
                r_out_status <= n_status;
                r_out_vld    <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld    <= 1'b0;
            end
        end
    end

    // result fields are the state after the step
    assign o_out.valid             = r_out_vld;
    assign o_out.out_channel       = r_channel;
    assign o_out.dac_code          = r_guess;
    assign o_out.status            = r_out_status;
    assign o_out.current_tolerance = r_tol;

`ifndef SYNTHESIS
    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_status == ST_DONE) |-> !r_searching)
        else $error("search still running after done result");
    a_ignored_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_status == ST_IGNORED) |-> !r_searching)
        else $error("reading ignored while searching");
    a_measure_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_status == ST_MEASURE) |-> r_searching)
        else $error("measure result without running search");
    a_step_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_searching |-> (r_prev == r_guess
                         || {1'b0, r_prev} == {1'b0, r_guess} + 17'd1
                         || {1'b0, r_prev} + 17'd1 == {1'b0, r_guess}))
        else $error("code moved by more than one step");
`endif

endmodule

FILE: design/dac_code_calibration_search.sv
// top level of the dac code calibration search
// Searches for the DAC code that produces a target voltage. A start beat
// (command 0) loads channel, target and invert flag and returns the first
// guess, floor(target * 65535 / 10 V) with the zero and full-scale substitute
// codes; each reading beat (command 1) steps the code one toward the target,
// widens the tolerance by a quarter on every direction reversal, and returns
// status 1 with the last stepped code once |reading - target| is within the
// tolerance. Voltages are Q16 volts. Unless stalled by the receiver or a full
// queue, the block takes one beat per clock and returns one result per beat;
// the rate is set by the back end, which then updates the search state once
// per cycle with a single compare-and-step. The first guess division is done
// ahead of it in a two-stage front pipeline (shift-subtract, then a reciprocal
// multiply), with a four-entry queue between the two so either side can stall.
// Configuration writes are always accepted and must only be issued when idle.
module dac_code_calibration_search import dccs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dccs_in_if.sink     i_in,
    dccs_out_if.source  o_out,
    dccs_cfg_if.sink    i_cfg
);

    t_cfg  r_cfg;
    t_item push_item;
    t_item pop_item;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;

    // configuration registers, writes beyond the list are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.init_tol  <= INIT_TOL_RST;
            r_cfg.zero_code <= ZERO_CODE_RST;
            r_cfg.full_code <= FULL_CODE_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_INIT_TOL:  r_cfg.init_tol  <= i_cfg.data;
                REG_ZERO_CODE: r_cfg.zero_code <= i_cfg.data;
                REG_FULL_CODE: r_cfg.full_code <= i_cfg.data;
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    // front: accept beat, classify, first guess
    dccs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_item  (push_item)
    );

    // decoupling queue
    dccs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_item  (pop_item),
        .o_empty (empty)
    );

    // back: search state and result register
    dccs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_init_tol (r_cfg.init_tol),
        .i_empty    (empty),
        .i_item     (pop_item),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

FILE: test/dac_code_calibration_search_checker.sv
// checker for the dac code calibration search: predicts every result beat and compares it
module dac_code_calibration_search_checker import dccs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    dccs_in_if   i_in_mon,
    dccs_out_if  i_out_mon,
    dccs_cfg_if  i_cfg_mon,
    output int   o_errors,
    output int   o_waiting
);

    localparam longint FULL_SCALE = longint'(TEN_VOLTS);

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic [CODE_W-1:0] code;
        logic [ST_W-1:0]   status;
        logic [TOL_W-1:0]  tol;
    } code_report_t;

    code_report_t pending_reports[$];
    int           mismatches;

    // register copies
    logic [CFG_W-1:0] cfg_init_tol;
    logic [CFG_W-1:0] cfg_zero_code;
    logic [CFG_W-1:0] cfg_full_code;

    // search state
    logic              hunting;
    logic [CODE_W-1:0] code_now;
    logic [CODE_W-1:0] code_last;
    logic [TOL_W-1:0]  window;
    logic [TGT_W-1:0]  aim;
    logic              flip;
    logic [CH_W-1:0]   chan;

    assign o_errors = mismatches;

    function automatic logic [TOL_W-1:0] widen(input logic [TOL_W-1:0] w);
        logic [TOL_W:0] sum;
        sum = {1'b0, w} + (w >> 2);
        return (sum > TOL_MAX) ? TOL_MAX : sum[TOL_W-1:0];
    endfunction

    function automatic logic [CODE_W-1:0] first_code(input logic [TGT_W-1:0] tgt);
        longint g;
        g = (longint'(tgt) * longint'(CODE_MAX)) / FULL_SCALE;
        if (g > longint'(CODE_MAX)) g = longint'(CODE_MAX);
        if (g == 0) return cfg_zero_code;
        if (g == longint'(CODE_MAX)) return cfg_full_code;
        return CODE_W'(g);
    endfunction

    function automatic code_report_t predict_step(
        input logic              cmd,
        input logic [CH_W-1:0]   ch,
        input logic [TGT_W-1:0]  tgt,
        input logic              inv,
        input logic [RD_IN_W-1:0] rd
    );
        code_report_t    rep;
        longint          volts;
        longint          gap;
        logic [ST_W-1:0] st;
        st = ST_MEASURE;
        if (cmd == CMD_START) begin
            chan      = ch;
            aim       = tgt;
            flip      = inv;
            code_now  = first_code(tgt);
            code_last = code_now;
            window    = TOL_W'(cfg_init_tol);
            hunting   = 1'b1;
        end else if (!hunting) begin
            st = ST_IGNORED;
        end else begin
            volts = longint'($signed(rd));
            if (flip) volts = FULL_SCALE - volts;
            if (volts > longint'(aim)) begin
                // stepping down after a step up is a reversal
                if (code_last < code_now) window = widen(window);
                code_last = code_now;
                if (code_now != '0) code_now = code_now - 1'b1;
            end else if (volts < longint'(aim)) begin
                if (code_last > code_now) window = widen(window);
                code_last = code_now;
                if (code_now != CODE_MAX) code_now = code_now + 1'b1;
            end
            gap = (volts > longint'(aim)) ? volts - longint'(aim) : longint'(aim) - volts;
            if (gap <= longint'(window)) begin
                hunting = 1'b0;
                st      = ST_DONE;
            end
        end
        rep.channel = chan;
        rep.code    = code_now;
        rep.status  = st;
        rep.tol     = window;
        return rep;
    endfunction

    function automatic void check_field(input string label, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : track
        code_report_t want;
        if (!i_rst_n) begin
            cfg_init_tol  = INIT_TOL_RST;
            cfg_zero_code = ZERO_CODE_RST;
            cfg_full_code = FULL_CODE_RST;
            hunting       = 1'b0;
            code_now      = '0;
            code_last     = '0;
            window        = TOL_W'(INIT_TOL_RST);
            aim           = '0;
            flip          = 1'b0;
            chan          = '0;
            mismatches    = 0;
            pending_reports.delete();
        end else begin
            // the result leaving now is older than any input taken at this edge
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (pending_reports.size() == 0) begin
                    $display("%0t: result beat with nothing expected, code %0d status %0d",
                             $time, i_out_mon.dac_code, i_out_mon.status);
                    mismatches++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("out_channel", want.channel, i_out_mon.out_channel);
                    check_field("dac_code", want.code, i_out_mon.dac_code);
                    check_field("status", want.status, i_out_mon.status);
                    check_field("current_tolerance", want.tol, i_out_mon.current_tolerance);
                end
            end
            if (i_cfg_mon.valid && i_cfg_mon.ready) begin
                case (i_cfg_mon.index)
                    REG_INIT_TOL:  cfg_init_tol = i_cfg_mon.data;
                    REG_ZERO_CODE: cfg_zero_code = i_cfg_mon.data;
                    REG_FULL_CODE: cfg_full_code = i_cfg_mon.data;
                    default: ;
                endcase
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                pending_reports.push_back(predict_step(i_in_mon.command, i_in_mon.channel,
                    i_in_mon.target_voltage, i_in_mon.invert_reading, i_in_mon.reading));
            end
        end
        o_waiting <= pending_reports.size();
    end

endmodule

FILE: test/dac_code_calibration_search_test.sv
// testbench top for the dac code calibration search: stimulus, stalls and verdict
module dac_code_calibration_search_test import dccs_pkg::*; ();

    localparam longint FULL_SCALE     = longint'(TEN_VOLTS);
    localparam int     WATCHDOG_LIMIT = 2000;  // cycles without any beat
    localparam int     PHASE_ITEMS    = 300;   // input beats per register setting
    localparam int     NUM_SETTINGS   = 6;
    localparam int     HOLD_AT        = 400;   // result count where the receiver holds off
    localparam int     HOLD_CYCLES    = 80;
    localparam int     DRAIN_CYCLES   = 8;     // extra wait after the last expected result

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   errors;
    int   waiting;
    int   beats_sent;
    bit   calm;  // no idling on either side while set

    dccs_in_if  in_bus();
    dccs_out_if out_bus();
    dccs_cfg_if cfg_bus();

    dac_code_calibration_search uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    dac_code_calibration_search_checker search_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_mon  (in_bus),
        .i_out_mon (out_bus),
        .i_cfg_mon (cfg_bus),
        .o_errors  (errors),
        .o_waiting (waiting)
    );

    always #1 i_clk = ~i_clk;

    // offer one input beat, sometimes after a short gap; valid stays high afterwards
    task automatic offer_beat(input logic cmd, input logic [CH_W-1:0] ch,
                              input logic [TGT_W-1:0] tgt, input logic inv,
                              input logic [RD_IN_W-1:0] rd);
        if (!calm && $urandom_range(99, 0) < 4) begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        in_bus.valid          <= 1'b1;
        in_bus.command        <= cmd;
        in_bus.channel        <= ch;
        in_bus.target_voltage <= tgt;
        in_bus.invert_reading <= inv;
        in_bus.reading        <= rd;
        do @(posedge i_clk); while (!in_bus.ready);
        beats_sent++;
    endtask

    // unused fields of a beat still carry random bits
    task automatic send_start(input logic [CH_W-1:0] ch, input logic [TGT_W-1:0] tgt,
                              input logic inv);
        offer_beat(CMD_START, ch, tgt, inv, RD_IN_W'($urandom));
    endtask

    task automatic send_reading(input logic [RD_IN_W-1:0] rd);
        offer_beat(CMD_READING, CH_W'($urandom), TGT_W'($urandom), 1'($urandom), rd);
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic drain();
        in_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge i_clk); while (!cfg_bus.ready);
    endtask

    task automatic load_settings(input logic [CFG_W-1:0] tol, input logic [CFG_W-1:0] zero_code,
                                 input logic [CFG_W-1:0] full_code);
        write_reg(REG_INIT_TOL, tol);
        write_reg(REG_ZERO_CODE, zero_code);
        write_reg(REG_FULL_CODE, full_code);
        cfg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // a start followed by readings scattered around the target, as a real loop would see
    task automatic random_search();
        logic [TGT_W-1:0] aim;
        logic             inv;
        int               steps;
        int               spread;
        longint           volts;
        case ($urandom_range(9, 0))
            0:       aim = '0;
            1:       aim = TGT_W'(FULL_SCALE);
            2:       aim = TGT_W'($urandom);  // may lie above 10 V
            3:       aim = TGT_W'($urandom_range(20, 0));
            default: aim = TGT_W'($urandom_range(int'(FULL_SCALE), 0));
        endcase
        inv = 1'($urandom);
        send_start(CH_W'($urandom), aim, inv);
        if ($urandom_range(99, 0) < 4) begin
            // the two extreme readings land on opposite sides of any target, so every
            // step after the first reverses and the window keeps growing toward saturation
            for (int k = 0; k < 30; k++) begin
                send_reading((k % 2 == 0) ? {1'b1, {(RD_IN_W-1){1'b0}}}
                                          : {1'b0, {(RD_IN_W-1){1'b1}}});
            end
        end else begin
            steps = $urandom_range(12, 1);
            case ($urandom_range(9, 0))
                0, 1, 2:          spread = 120;
                3, 4, 5, 6, 7:    spread = 4000;
                default:          spread = 700000;
            endcase
            repeat (steps) begin
                volts = longint'(aim) + longint'($urandom_range(2 * spread, 0)) - spread;
                if (inv) volts = FULL_SCALE - volts;
                send_reading(RD_IN_W'(volts));
            end
        end
    endtask

    // receiver: random stalls, one long hold-off that backs the block up to its input
    initial begin : receiver
        int  results_seen;
        bit  held;
        results_seen = 0;
        held         = 1'b0;
        out_bus.ready <= 1'b0;
        forever begin
            if (results_seen == HOLD_AT && !held) begin
                held = 1'b1;
                out_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                out_bus.ready <= calm || ($urandom_range(99, 0) >= 10);
            end
            @(posedge i_clk);
            if (out_bus.valid && out_bus.ready) results_seen++;
        end
    end

    // watchdog: ends the run when no channel moves a beat for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("dac_code_calibration_search_test: errors");
        $finish;
    end

    initial begin : stimulus
        int phase_base;
        i_rst_n               <= 1'b0;
        in_bus.valid          <= 1'b0;
        in_bus.command        <= CMD_START;
        in_bus.channel        <= '0;
        in_bus.target_voltage <= '0;
        in_bus.invert_reading <= 1'b0;
        in_bus.reading        <= '0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.index         <= REG_INIT_TOL;
        cfg_bus.data          <= '0;
        calm       = 1'b0;
        beats_sent = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed checks at reset register values
        send_reading(RD_IN_W'($urandom));               // reading before any search
        send_start(2'd3, '0, 1'b0);                      // zero guess substitute
        send_reading('0);                                // exact match ends at once
        send_start(2'd1, TGT_W'(FULL_SCALE), 1'b0);      // full-scale substitute
        send_start(2'd2, '1, 1'b1);                      // above 10 V, restart mid search
        send_reading('0);                                // inverted to 10 V, below target
        send_start(2'd0, TGT_W'(FULL_SCALE / 2), 1'b1);
        send_reading(RD_IN_W'(-FULL_SCALE));             // far above after inversion
        send_reading({1'b0, {(RD_IN_W-1){1'b1}}});       // most positive, reverses
        send_reading({1'b1, {(RD_IN_W-1){1'b0}}});       // most negative, reverses again
        send_reading(RD_IN_W'(FULL_SCALE));              // inverted to 0 V
        send_reading(RD_IN_W'(FULL_SCALE / 2 - 10));     // just inside the window
        send_reading(RD_IN_W'($urandom));                // ignored after finishing
        send_start(2'd1, TGT_W'(10), 1'b0);              // tiny target rounds to zero
        send_reading(RD_IN_W'(5010));
        send_reading(RD_IN_W'(10));
        send_start(2'd2, TGT_W'(100000), 1'b0);
        send_reading(RD_IN_W'(100300));
        send_reading(RD_IN_W'(99700));
        send_reading(RD_IN_W'(100300));
        send_reading(RD_IN_W'(100000));

        for (int p = 0; p < NUM_SETTINGS; p++) begin
            if (p > 0) begin
                drain();
                case (p)
                    1:       load_settings('0, '0, CODE_MAX);
                    2:       load_settings('1, '1, '0);
                    3:       load_settings(CFG_W'(1), CFG_W'(1234), CFG_W'(60000));
                    4:       load_settings(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
                    default: load_settings(INIT_TOL_RST, ZERO_CODE_RST, FULL_CODE_RST);
                endcase
            end
            if (p == 1) begin
                // zero window and end codes: stepping pins at both rails
                send_start(2'd0, '0, 1'b0);
                send_reading(RD_IN_W'(1000));
                send_reading(RD_IN_W'(-1000));
                send_reading('0);
                send_start(2'd1, '1, 1'b0);
                send_reading(RD_IN_W'(-5));
                send_reading(RD_IN_W'(TOL_MAX));
            end
            // one whole phase without idling on either side
            calm       = (p == 3);
            phase_base = beats_sent;
            while (beats_sent - phase_base < PHASE_ITEMS) begin
                if ($urandom_range(99, 0) < 10) begin
                    // noise: stray readings and starts with arbitrary fields
                    if ($urandom_range(1, 0) == 0)
                        send_reading(RD_IN_W'($urandom));
                    else
                        send_start(CH_W'($urandom), TGT_W'($urandom), 1'($urandom));
                end else begin
                    random_search();
                end
            end
        end
        calm = 1'b0;

        drain();
        if (errors == 0)
            $display("dac_code_calibration_search_test: clean");
        else
            $display("dac_code_calibration_search_test: errors");
        $finish;
    end

endmodule

FILE: filelist.f
design/dccs_pkg.sv
design/dccs_if.sv
design/dccs_front.sv
design/dccs_fifo.sv
design/dccs_back.sv
design/dac_code_calibration_search.sv
test/dac_code_calibration_search_checker.sv
test/dac_code_calibration_search_test.sv
